// File: sv/gated_descriptor_distance_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gated descriptor distance block
// Immediate-cycle and next-cycle implication checks on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GATED_DESCRIPTOR_DISTANCE_ASSERT_SVH
`define GATED_DESCRIPTOR_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define GDD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define GDD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GDD_ASSERT_IMP(label, ante, cons, msg)
`define GDD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: sv/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// Widths, status codes and item type for the gated descriptor distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdd_pkg;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int SUM_W  = 44;
  localparam int ROOT_W = SUM_W / 2;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_DIM_ERR = 2'd2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] det_elem;
    logic signed [ELEM_W-1:0] trk_elem;
    logic                     first;
    logic                     last;
    logic                     det_has_features;
    logic                     trk_has_detection;
    logic                     trk_has_features;
    logic signed [ELEM_W-1:0] trk_center_x;
    logic signed [ELEM_W-1:0] trk_center_y;
    logic signed [ELEM_W-1:0] det_center_x;
    logic signed [ELEM_W-1:0] det_center_y;
    logic                     lengths_differ;
  } gdd_pair_t;

endpackage

`default_nettype wire

// File: sv/gdd_pair_if.sv
// ----------------------------------------------------------------------------
// gdd_pair_if
// Valid/ready channel carrying one descriptor element pair item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gdd_pair_if;
  import gdd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] det_elem;
  logic signed [ELEM_W-1:0] trk_elem;
  logic                     first;
  logic                     last;
  logic                     det_has_features;
  logic                     trk_has_detection;
  logic                     trk_has_features;
  logic signed [ELEM_W-1:0] trk_center_x;
  logic signed [ELEM_W-1:0] trk_center_y;
  logic signed [ELEM_W-1:0] det_center_x;
  logic signed [ELEM_W-1:0] det_center_y;
  logic                     lengths_differ;

  modport source (
    output valid, det_elem, trk_elem, first, last, det_has_features,
           trk_has_detection, trk_has_features, trk_center_x, trk_center_y,
           det_center_x, det_center_y, lengths_differ,
    input  ready
  );

  modport sink (
    input  valid, det_elem, trk_elem, first, last, det_has_features,
           trk_has_detection, trk_has_features, trk_center_x, trk_center_y,
           det_center_x, det_center_y, lengths_differ,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/gdd_result_if.sv
// ----------------------------------------------------------------------------
// gdd_result_if
// Valid/ready channel carrying one distance result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gdd_result_if;
  import gdd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] distance;
  logic [STAT_W-1:0] status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);

endinterface

`default_nettype wire

// File: sv/gdd_isqrt.sv
// ----------------------------------------------------------------------------
// gdd_isqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdd_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gdd_pkg::SUM_W-1:0]  radicand,
  output logic                       done,
  output logic [gdd_pkg::ROOT_W-1:0] root
);
  import gdd_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 3;

  logic [SUM_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[SUM_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W - 1);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[SUM_W-3:0], 2'b00};
        rem  <= take ? (rem_sh - trial) : rem_sh;
        root <= {root[ROOT_W-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gated_descriptor_distance.sv
// ----------------------------------------------------------------------------
// gated_descriptor_distance
// One track-detection cell: gated, accumulated descriptor distance.
// ----------------------------------------------------------------------------
// Usage:
//   pairs  : one element pair item per handshake, first to last, with the
//            presence flags, box centres and length flag sampled on first.
//   result : one item per last item: distance (Q14.8) and status.
//   cfg    : cfg_wr_en / cfg_wr_data write max_distance; zero disables gating.
// Sequence:
//   A plain element item takes the steps accept, square and accumulate on the
//   single shared 16x16 squarer. A first item that is gated adds steps
//   for the two centre squares, the threshold square and the compare.
//   A last item of a usable pair with equal lengths adds S_ROOT_GO and S_ROOT_WAIT
//   for the 22-step root unit, then S_FIN loads the result register; else only S_FIN.
//   pairs.ready is high only when the sequencer is idle.
// Reset: clears the sum, the latched flags, max_distance and result.valid.
// Stall: a result waits in its register; the next pair is still taken and
//   processed, holding only if a new result is due before the old one left.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gated_descriptor_distance_assert.svh"

module gated_descriptor_distance (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [gdd_pkg::ELEM_W-1:0] cfg_wr_data,
  gdd_pair_if.sink                   pairs,
  gdd_result_if.source               result
);
  import gdd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GATE_DX, S_GATE_DY, S_GATE_MD, S_GATE_CMP,
    S_ELEM, S_ACC, S_ROOT_GO, S_ROOT_WAIT, S_FIN
  } state_t;

  state_t            state;
  gdd_pair_t         item;
  logic [ELEM_W-1:0] max_distance;
  logic [SUM_W-1:0]  sum_of_squares;
  logic              pair_usable;
  logic              dims_error;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   gate_acc;

  logic              accept;
  logic              flags_ok;
  logic [ELEM_W-1:0] op_a;
  logic [ELEM_W-1:0] op_b;
  logic              op_direct;
  logic [ELEM_W:0]   diff;
  logic [ELEM_W-1:0] mag;
  logic [PROD_W-1:0] sq;
  logic [SUM_W:0]    sum_add;
  logic              root_start;
  logic              root_done;
  logic [ROOT_W-1:0] root;

  assign pairs.ready = (state == S_IDLE);
  assign accept      = pairs.valid && pairs.ready;
  assign flags_ok    = pairs.det_has_features && pairs.trk_has_detection &&
                       pairs.trk_has_features;
  assign root_start  = (state == S_ROOT_GO);

  // shared squarer operand select
  always_comb begin
    op_a      = item.det_elem;
    op_b      = item.trk_elem;
    op_direct = 1'b0;
    case (state)
      S_GATE_DX: begin
        op_a = item.trk_center_x;
        op_b = item.det_center_x;
      end
      S_GATE_DY: begin
        op_a = item.trk_center_y;
        op_b = item.det_center_y;
      end
      S_GATE_MD: begin
        op_a      = max_distance;
        op_direct = 1'b1;
      end
      default: begin
        op_a = item.det_elem;
        op_b = item.trk_elem;
      end
    endcase
    diff = {op_a[ELEM_W-1], op_a} - {op_b[ELEM_W-1], op_b};
    if (op_direct) begin
      mag = op_a;
    end else if (diff[ELEM_W]) begin
      mag = ELEM_W'(-diff);
    end else begin
      mag = diff[ELEM_W-1:0];
    end
    sq      = PROD_W'(mag * mag);
    sum_add = {1'b0, sum_of_squares} + (SUM_W+1)'(prod);
  end

  gdd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sum_of_squares),
    .done     (root_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= '0;
    end else if (cfg_wr_en) begin
      max_distance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sum_of_squares <= '0;
      pair_usable    <= 1'b0;
      dims_error     <= 1'b0;
      result.valid   <= 1'b0;
    end else begin
      if (result.valid && result.ready && (state != S_FIN)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= '{pairs.det_elem, pairs.trk_elem, pairs.first, pairs.last,
                      pairs.det_has_features, pairs.trk_has_detection,
                      pairs.trk_has_features, pairs.trk_center_x,
                      pairs.trk_center_y, pairs.det_center_x,
                      pairs.det_center_y, pairs.lengths_differ};
            if (pairs.first) begin
              pair_usable <= flags_ok;
              dims_error  <= pairs.lengths_differ;
            end
            if (pairs.first && flags_ok && (max_distance != '0)) begin
              state <= S_GATE_DX;
            end else begin
              state <= S_ELEM;
            end
          end
        end
        S_GATE_DX: begin
          prod  <= sq;
          state <= S_GATE_DY;
        end
        S_GATE_DY: begin
          gate_acc <= {1'b0, prod};
          prod     <= sq;
          state    <= S_GATE_MD;
        end
        S_GATE_MD: begin
          gate_acc <= gate_acc + {1'b0, prod};
          prod     <= sq;
          state    <= S_GATE_CMP;
        end
        S_GATE_CMP: begin
          pair_usable <= (gate_acc < {1'b0, prod});
          state       <= S_ELEM;
        end
        S_ELEM: begin
          prod  <= sq;
          state <= S_ACC;
        end
        S_ACC: begin
          if (item.first) begin
            sum_of_squares <= SUM_W'(prod);
          end else if (sum_add[SUM_W]) begin
            sum_of_squares <= '1;
          end else begin
            sum_of_squares <= sum_add[SUM_W-1:0];
          end
          if (!item.last) begin
            state <= S_IDLE;
          end else if (pair_usable && !dims_error) begin
            state <= S_ROOT_GO;
          end else begin
            state <= S_FIN;
          end
        end
        S_ROOT_GO: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (root_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            if (!pair_usable) begin
              result.distance <= '0;
              result.status   <= STATUS_INVALID;
            end else if (dims_error) begin
              result.distance <= '0;
              result.status   <= STATUS_DIM_ERR;
            end else begin
              result.distance <= root;
              result.status   <= STATUS_OK;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GDD_ASSERT_IMP(a_dist_only_valid, result.valid && (result.distance != '0), result.status == STATUS_OK, "nonzero distance without valid status")
  `GDD_ASSERT_NXT(a_one_item_at_a_time, accept, !pairs.ready, "pair taken while busy")
  `GDD_ASSERT_IMP(a_root_done_in_wait, root_done, state == S_ROOT_WAIT, "root finished outside wait")
  `GDD_ASSERT_NXT(a_fin_loads_result, (state == S_FIN) && (!result.valid || result.ready), result.valid, "result not loaded")

endmodule

`default_nettype wire
